>>> sv/bcrt_pkg.sv
`default_nettype none

package bcrt_pkg;

  // Store depth and field widths.
  localparam int MAX_LADDERS = 16;
  localparam int HEIGHT_BITS = 20;
  localparam int BUDGET_BITS = 30;
  localparam int LADDER_BITS = 5;
  localparam int REACH_BITS  = 16;
  localparam int COUNT_BITS  = $clog2(MAX_LADDERS + 1);
  localparam int CFG_DATA_BITS = BUDGET_BITS;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_BRICK_BUDGET = 1'b0,
    CFG_LADDER_COUNT = 1'b1
  } cfg_index_t;

  // One input item.
  typedef struct packed {
    logic [HEIGHT_BITS-1:0] height;
    logic                   new_sequence;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [REACH_BITS-1:0] reach;
    logic                  blocked;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/bcrt_ctrl.sv
`default_nettype none

module bcrt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output bcrt_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT
  } state_t;

  state_t state;

  // Commands for this cycle; commit waits for a free output slot.
  always_comb begin
    cmd.load   = (state == ST_IDLE) && in_valid;
    cmd.eval   = (state == ST_EVAL);
    cmd.commit = (state == ST_COMMIT) && (!out_valid || !out_stall);
  end

  assign in_stall = (state != ST_IDLE);

  // State and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_EVAL;
        end
        ST_EVAL: begin
          state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (!out_valid || !out_stall) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/bcrt_datapath.sv
`default_nettype none

module bcrt_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire bcrt_pkg::cfg_index_t               cfg_index,
  input  wire logic [bcrt_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  wire bcrt_pkg::in_t                      in_item,
  input  wire bcrt_pkg::cmd_t                     cmd,
  output bcrt_pkg::out_t                          out_item
);

  localparam int HB = bcrt_pkg::HEIGHT_BITS;
  localparam int BB = bcrt_pkg::BUDGET_BITS;
  localparam int CB = bcrt_pkg::COUNT_BITS;
  localparam int RB = bcrt_pkg::REACH_BITS;
  localparam int ML = bcrt_pkg::MAX_LADDERS;

  // Configuration registers.
  logic [BB-1:0]                    brick_budget;
  logic [bcrt_pkg::LADDER_BITS-1:0] ladder_count;

  // Walk state.
  logic [HB-1:0] previous_height;
  logic [HB-1:0] kept_rises [ML];
  logic [CB-1:0] rises_kept_count;
  logic [BB-1:0] bricks_left;
  logic [RB-1:0] reach_count;
  logic          stopped;

  // Latched input item.
  logic [HB-1:0] height_q;
  logic          start_q;

  // Evaluation results.
  logic [HB-1:0] rise_q;
  logic [HB-1:0] cost_q;
  logic          rising_q;
  logic          insert_q;
  logic          replace_q;
  logic [ML:0]   le_q;

  logic [HB-1:0] rise;
  logic [CB-1:0] ladders;
  logic          have;
  logic [ML:0]   le;

  logic [HB-1:0] kept_ins [ML];
  logic [HB-1:0] kept_rep [ML];
  logic          over;
  logic [RB-1:0] reach_inc;

  logic [CB-1:0] rises_kept_count_next;
  logic [BB-1:0] bricks_left_next;
  logic [RB-1:0] reach_count_next;
  logic          stopped_next;
  logic          prev_update;
  logic          do_insert;
  logic          do_replace;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      brick_budget <= '0;
      ladder_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcrt_pkg::CFG_BRICK_BUDGET: brick_budget <= cfg_data[BB-1:0];
        bcrt_pkg::CFG_LADDER_COUNT: ladder_count <= cfg_data[bcrt_pkg::LADDER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Evaluation: the rise, its cost and where it falls in the sorted store.
  always_comb begin
    rise    = height_q - previous_height;
    ladders = (int'(ladder_count) > ML) ? CB'(ML) : CB'(ladder_count);
    have    = (rises_kept_count != '0);
    for (int i = 0; i < ML; i++) begin
      le[i] = (CB'(i) < rises_kept_count) && (kept_rises[i] <= rise);
    end
    le[ML] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      height_q <= in_item.height;
      start_q  <= in_item.new_sequence;
    end
    if (cmd.eval) begin
      rise_q    <= rise;
      rising_q  <= (height_q > previous_height);
      insert_q  <= (rises_kept_count < ladders);
      cost_q    <= (have && (kept_rises[0] < rise)) ? kept_rises[0] : rise;
      replace_q <= have && (rise > kept_rises[0]);
      le_q      <= le;
    end
  end

  // Cell row: sorted insertion and replacement of the smallest entry.
  always_comb begin
    for (int i = 0; i < ML; i++) begin
      if (le_q[i]) begin
        kept_ins[i] = kept_rises[i];
      end else if (i == 0) begin
        kept_ins[i] = rise_q;
      end else if (le_q[(i == 0) ? 0 : i - 1]) begin
        kept_ins[i] = rise_q;
      end else begin
        kept_ins[i] = kept_rises[(i == 0) ? 0 : i - 1];
      end
      if (le_q[i + 1]) begin
        kept_rep[i] = kept_rises[(i + 1 < ML) ? i + 1 : i];
      end else if ((i == 0) || le_q[i]) begin
        kept_rep[i] = rise_q;
      end else begin
        kept_rep[i] = kept_rises[i];
      end
    end
  end

  // Next walk state for the current item.
  always_comb begin
    over      = (BB'(cost_q) > bricks_left);
    reach_inc = (reach_count == '1) ? reach_count : reach_count + RB'(1);

    rises_kept_count_next = rises_kept_count;
    bricks_left_next      = bricks_left;
    reach_count_next      = reach_count;
    stopped_next          = stopped;
    prev_update           = 1'b0;
    do_insert             = 1'b0;
    do_replace            = 1'b0;

    if (start_q) begin
      rises_kept_count_next = '0;
      bricks_left_next      = brick_budget;
      reach_count_next      = '0;
      stopped_next          = 1'b0;
      prev_update           = 1'b1;
    end else if (!stopped) begin
      prev_update = 1'b1;
      if (!rising_q) begin
        reach_count_next = reach_inc;
      end else if (insert_q) begin
        do_insert             = 1'b1;
        rises_kept_count_next = rises_kept_count + CB'(1);
        reach_count_next      = reach_inc;
      end else if (over) begin
        stopped_next = 1'b1;
        prev_update  = 1'b0;
      end else begin
        bricks_left_next = bricks_left - BB'(cost_q);
        reach_count_next = reach_inc;
        do_replace       = replace_q;
      end
    end
  end

  // Walk state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_height  <= '0;
      rises_kept_count <= '0;
      bricks_left      <= '0;
      reach_count      <= '0;
      stopped          <= 1'b0;
    end else if (cmd.commit) begin
      rises_kept_count <= rises_kept_count_next;
      bricks_left      <= bricks_left_next;
      reach_count      <= reach_count_next;
      stopped          <= stopped_next;
      if (prev_update) previous_height <= height_q;
    end
  end

  // Store cells hold no reset value; only counted entries are read.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < ML; i++) begin
        if (do_insert) begin
          kept_rises[i] <= kept_ins[i];
        end else if (do_replace) begin
          kept_rises[i] <= kept_rep[i];
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item.reach   <= reach_count_next;
      out_item.blocked <= stopped_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/budgeted_climb_reach_tracker.sv
`default_nettype none

// Budgeted climb reach tracker.
// Heights arrive on the input channel (in_valid, in_stall, in_item); an item
// is taken at a clock edge where in_valid is high and in_stall is low. Setting
// new_sequence starts a new walk and loads the brick budget.
// Each item gives exactly one result item on the output channel (out_valid,
// out_stall, out_item): the furthest index reached and the blocked flag.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while idle, as the block itself does not enforce this.
// Each item passes the load, evaluate and commit steps, and no new item is
// taken until it commits; the sorted rise store is written at the commit step.
// While a result waits under out_stall, the next item is still taken and
// evaluated; its commit waits until the output register is free.
// Synchronous reset clears the registers, the walk state and the output valid
// flag; the rise store needs no clearing pass.
module budgeted_climb_reach_tracker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire bcrt_pkg::cfg_index_t               cfg_index,
  input  wire logic [bcrt_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire bcrt_pkg::in_t                      in_item,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output bcrt_pkg::out_t                          out_item
);

  bcrt_pkg::cmd_t cmd;

  // Sequencer.
  bcrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Walk state, rise store and output register.
  bcrt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
